/* design/c65eu_pkg.sv */
// Shared types and codes for the 6502 execute unit.
// Request and response words, the architectural state record and the operation codes.
// No dependencies.
package c65eu_pkg;

   // Operation codes carried in the mode field of a request word
   localparam logic [5:0] MODE_LDA   = 6'd0;
   localparam logic [5:0] MODE_LDX   = 6'd1;
   localparam logic [5:0] MODE_LDY   = 6'd2;
   localparam logic [5:0] MODE_STA   = 6'd3;
   localparam logic [5:0] MODE_STX   = 6'd4;
   localparam logic [5:0] MODE_STY   = 6'd5;
   localparam logic [5:0] MODE_TAX   = 6'd6;
   localparam logic [5:0] MODE_TAY   = 6'd7;
   localparam logic [5:0] MODE_TXA   = 6'd8;
   localparam logic [5:0] MODE_TYA   = 6'd9;
   localparam logic [5:0] MODE_TSX   = 6'd10;
   localparam logic [5:0] MODE_TXS   = 6'd11;
   localparam logic [5:0] MODE_ADC   = 6'd12;
   localparam logic [5:0] MODE_SBC   = 6'd13;
   localparam logic [5:0] MODE_AND   = 6'd14;
   localparam logic [5:0] MODE_ORA   = 6'd15;
   localparam logic [5:0] MODE_EOR   = 6'd16;
   localparam logic [5:0] MODE_CMP   = 6'd17;
   localparam logic [5:0] MODE_CPX   = 6'd18;
   localparam logic [5:0] MODE_CPY   = 6'd19;
   localparam logic [5:0] MODE_BIT   = 6'd20;
   localparam logic [5:0] MODE_INC   = 6'd21;
   localparam logic [5:0] MODE_DEC   = 6'd22;
   localparam logic [5:0] MODE_INX   = 6'd23;
   localparam logic [5:0] MODE_INY   = 6'd24;
   localparam logic [5:0] MODE_DEX   = 6'd25;
   localparam logic [5:0] MODE_DEY   = 6'd26;
   localparam logic [5:0] MODE_ASL_A = 6'd27;
   localparam logic [5:0] MODE_ASL_M = 6'd28;
   localparam logic [5:0] MODE_LSR_A = 6'd29;
   localparam logic [5:0] MODE_LSR_M = 6'd30;
   localparam logic [5:0] MODE_ROL_A = 6'd31;
   localparam logic [5:0] MODE_ROL_M = 6'd32;
   localparam logic [5:0] MODE_ROR_A = 6'd33;
   localparam logic [5:0] MODE_ROR_M = 6'd34;
   localparam logic [5:0] MODE_SEC   = 6'd35;
   localparam logic [5:0] MODE_CLC   = 6'd36;
   localparam logic [5:0] MODE_SEI   = 6'd37;
   localparam logic [5:0] MODE_CLI   = 6'd38;
   localparam logic [5:0] MODE_SED   = 6'd39;
   localparam logic [5:0] MODE_CLD   = 6'd40;
   localparam logic [5:0] MODE_CLV   = 6'd41;
   localparam logic [5:0] MODE_PHA   = 6'd42;
   localparam logic [5:0] MODE_PHP   = 6'd43;
   localparam logic [5:0] MODE_PLA   = 6'd44;
   localparam logic [5:0] MODE_PLP   = 6'd45;

   // Status bit positions, NV1BDIZC
   localparam int FLAG_C = 0;
   localparam int FLAG_Z = 1;
   localparam int FLAG_I = 2;
   localparam int FLAG_D = 3;
   localparam int FLAG_B = 4;
   localparam int FLAG_U = 5;
   localparam int FLAG_V = 6;
   localparam int FLAG_N = 7;

   localparam logic [7:0] RESET_SP    = 8'hFD;
   localparam logic [7:0] RESET_FLAGS = 8'h24;

   typedef struct packed {
      logic [5:0] mode;
      logic [7:0] operand;
   } req_word_type;

   typedef struct packed {
      logic [7:0] store_data;
      logic       store_enable;
      logic       stack_access;
      logic [7:0] stack_slot;
      logic [7:0] acc_out;
      logic [7:0] xreg_out;
      logic [7:0] yreg_out;
      logic [7:0] flags_out;
      logic [7:0] sp_out;
   } rsp_word_type;

   typedef struct packed {
      logic [7:0] acc;
      logic [7:0] xreg;
      logic [7:0] yreg;
      logic [7:0] sp;
      logic [7:0] flags;
   } arch_state_type;

endpackage

/* design/c65eu_exec.sv */
// Execute logic of the 6502 execute unit: one operation against the current state.
// Purely combinational; produces the next state and the response word.
// Depends on c65eu_pkg.
module c65eu_exec
   import c65eu_pkg::*;
(
   input  req_word_type   req_word,
   input  arch_state_type cur_state,
   output arch_state_type nxt_state,
   output rsp_word_type   rsp_word
);

   logic [7:0] m;
   logic [7:0] adc_m;
   logic [8:0] adc_sum;
   logic [7:0] adc_res;
   logic       adc_ovf;
   logic [7:0] cmp_reg;
   logic [8:0] cmp_diff;
   logic       sh_mem;
   logic       sh_left;
   logic       sh_rot;
   logic [7:0] sh_src;
   logic [7:0] sh_res;
   logic       sh_cout;
   logic       cin;
   logic       nz_en;
   logic [7:0] nz_val;
   logic [7:0] store_data;
   logic       store_enable;
   logic       stack_access;
   logic [7:0] stack_slot;

   assign m   = req_word.operand;
   assign cin = cur_state.flags[FLAG_C];

   // Binary add; subtract adds the inverted operand
   assign adc_m   = (req_word.mode == MODE_SBC) ? ~m : m;
   assign adc_sum = {1'b0, cur_state.acc} + {1'b0, adc_m} + {8'd0, cin};
   assign adc_res = adc_sum[7:0];
   assign adc_ovf = ~(cur_state.acc[7] ^ adc_m[7]) & (cur_state.acc[7] ^ adc_res[7]);

   always_comb begin
      case (req_word.mode)
         MODE_CPX: cmp_reg = cur_state.xreg;
         MODE_CPY: cmp_reg = cur_state.yreg;
         default:  cmp_reg = cur_state.acc;
      endcase
   end
   assign cmp_diff = {1'b0, cmp_reg} - {1'b0, m};

   // Shared shifter for accumulator and memory variants
   assign sh_mem  = req_word.mode inside {MODE_ASL_M, MODE_LSR_M, MODE_ROL_M, MODE_ROR_M};
   assign sh_left = req_word.mode inside {MODE_ASL_A, MODE_ASL_M, MODE_ROL_A, MODE_ROL_M};
   assign sh_rot  = req_word.mode inside {MODE_ROL_A, MODE_ROL_M, MODE_ROR_A, MODE_ROR_M};
   assign sh_src  = sh_mem ? m : cur_state.acc;
   assign sh_res  = sh_left ? {sh_src[6:0], sh_rot & cin} : {sh_rot & cin, sh_src[7:1]};
   assign sh_cout = sh_left ? sh_src[7] : sh_src[0];

   always_comb begin
      nxt_state    = cur_state;
      nz_en        = 1'b0;
      nz_val       = 8'd0;
      store_data   = 8'd0;
      store_enable = 1'b0;
      stack_access = 1'b0;
      stack_slot   = 8'd0;
      case (req_word.mode)
         MODE_LDA: begin
            nxt_state.acc = m; nz_en = 1'b1; nz_val = m;
         end
         MODE_LDX: begin
            nxt_state.xreg = m; nz_en = 1'b1; nz_val = m;
         end
         MODE_LDY: begin
            nxt_state.yreg = m; nz_en = 1'b1; nz_val = m;
         end
         MODE_STA: begin
            store_data = cur_state.acc; store_enable = 1'b1;
         end
         MODE_STX: begin
            store_data = cur_state.xreg; store_enable = 1'b1;
         end
         MODE_STY: begin
            store_data = cur_state.yreg; store_enable = 1'b1;
         end
         MODE_TAX: begin
            nxt_state.xreg = cur_state.acc; nz_en = 1'b1; nz_val = cur_state.acc;
         end
         MODE_TAY: begin
            nxt_state.yreg = cur_state.acc; nz_en = 1'b1; nz_val = cur_state.acc;
         end
         MODE_TXA: begin
            nxt_state.acc = cur_state.xreg; nz_en = 1'b1; nz_val = cur_state.xreg;
         end
         MODE_TYA: begin
            nxt_state.acc = cur_state.yreg; nz_en = 1'b1; nz_val = cur_state.yreg;
         end
         MODE_TSX: begin
            nxt_state.xreg = cur_state.sp; nz_en = 1'b1; nz_val = cur_state.sp;
         end
         MODE_TXS: begin
            nxt_state.sp = cur_state.xreg;
         end
         MODE_ADC, MODE_SBC: begin
            nxt_state.acc          = adc_res;
            nxt_state.flags[FLAG_V] = adc_ovf;
            nxt_state.flags[FLAG_C] = adc_sum[8];
            nz_en = 1'b1; nz_val = adc_res;
         end
         MODE_AND: begin
            nxt_state.acc = cur_state.acc & m; nz_en = 1'b1; nz_val = cur_state.acc & m;
         end
         MODE_ORA: begin
            nxt_state.acc = cur_state.acc | m; nz_en = 1'b1; nz_val = cur_state.acc | m;
         end
         MODE_EOR: begin
            nxt_state.acc = cur_state.acc ^ m; nz_en = 1'b1; nz_val = cur_state.acc ^ m;
         end
         MODE_CMP, MODE_CPX, MODE_CPY: begin
            nxt_state.flags[FLAG_C] = ~cmp_diff[8];
            nz_en = 1'b1; nz_val = cmp_diff[7:0];
         end
         MODE_BIT: begin
            nxt_state.flags[FLAG_Z] = ((cur_state.acc & m) == 8'd0);
            nxt_state.flags[FLAG_N] = m[7];
            nxt_state.flags[FLAG_V] = m[6];
         end
         MODE_INC: begin
            store_data = m + 8'd1; store_enable = 1'b1;
            nz_en = 1'b1; nz_val = m + 8'd1;
         end
         MODE_DEC: begin
            store_data = m - 8'd1; store_enable = 1'b1;
            nz_en = 1'b1; nz_val = m - 8'd1;
         end
         MODE_INX: begin
            nxt_state.xreg = cur_state.xreg + 8'd1;
            nz_en = 1'b1; nz_val = cur_state.xreg + 8'd1;
         end
         MODE_INY: begin
            nxt_state.yreg = cur_state.yreg + 8'd1;
            nz_en = 1'b1; nz_val = cur_state.yreg + 8'd1;
         end
         MODE_DEX: begin
            nxt_state.xreg = cur_state.xreg - 8'd1;
            nz_en = 1'b1; nz_val = cur_state.xreg - 8'd1;
         end
         MODE_DEY: begin
            nxt_state.yreg = cur_state.yreg - 8'd1;
            nz_en = 1'b1; nz_val = cur_state.yreg - 8'd1;
         end
         MODE_ASL_A, MODE_LSR_A, MODE_ROL_A, MODE_ROR_A: begin
            nxt_state.acc           = sh_res;
            nxt_state.flags[FLAG_C] = sh_cout;
            nz_en = 1'b1; nz_val = sh_res;
         end
         MODE_ASL_M, MODE_LSR_M, MODE_ROL_M, MODE_ROR_M: begin
            store_data = sh_res; store_enable = 1'b1;
            nxt_state.flags[FLAG_C] = sh_cout;
            nz_en = 1'b1; nz_val = sh_res;
         end
         MODE_SEC: nxt_state.flags[FLAG_C] = 1'b1;
         MODE_CLC: nxt_state.flags[FLAG_C] = 1'b0;
         MODE_SEI: nxt_state.flags[FLAG_I] = 1'b1;
         MODE_CLI: nxt_state.flags[FLAG_I] = 1'b0;
         MODE_SED: nxt_state.flags[FLAG_D] = 1'b1;
         MODE_CLD: nxt_state.flags[FLAG_D] = 1'b0;
         MODE_CLV: nxt_state.flags[FLAG_V] = 1'b0;
         MODE_PHA, MODE_PHP: begin
            // PHP pushes status with break and unused bits forced on
            if (req_word.mode == MODE_PHA) begin
               store_data = cur_state.acc;
            end else begin
               store_data = cur_state.flags;
               store_data[FLAG_U] = 1'b1;
               store_data[FLAG_B] = 1'b1;
            end
            store_enable = 1'b1;
            stack_access = 1'b1;
            stack_slot   = cur_state.sp;
            nxt_state.sp = cur_state.sp - 8'd1;
         end
         MODE_PLA: begin
            nxt_state.sp  = cur_state.sp + 8'd1;
            nxt_state.acc = m;
            nz_en = 1'b1; nz_val = m;
         end
         MODE_PLP: begin
            // keep the live break bit, force the unused bit
            nxt_state.sp            = cur_state.sp + 8'd1;
            nxt_state.flags         = m;
            nxt_state.flags[FLAG_B] = cur_state.flags[FLAG_B];
            nxt_state.flags[FLAG_U] = 1'b1;
         end
         default: begin
         end
      endcase
      if (nz_en) begin
         nxt_state.flags[FLAG_Z] = (nz_val == 8'd0);
         nxt_state.flags[FLAG_N] = nz_val[7];
      end
   end

   always_comb begin
      rsp_word.store_data   = store_data;
      rsp_word.store_enable = store_enable;
      rsp_word.stack_access = stack_access;
      rsp_word.stack_slot   = stack_slot;
      rsp_word.acc_out      = nxt_state.acc;
      rsp_word.xreg_out     = nxt_state.xreg;
      rsp_word.yreg_out     = nxt_state.yreg;
      rsp_word.flags_out    = nxt_state.flags;
      rsp_word.sp_out       = nxt_state.sp;
   end

endmodule

/* design/cpu_6502_execute_unit.sv */
// Top level of the 6502 execute unit: input register, execute logic, result register.
// Holds A, X, Y, SP and the status byte between operations.
// Depends on c65eu_pkg and c65eu_exec.
//
// Result path: a word taken on req is held in the input register, run through the execute
//   logic and held in the result register, where rsp_valid shows it until rsp accepts it.
// Throughput: one word per cycle while rsp is not stalled; the loop through the state registers and
//   the execute logic lets each operation see the state the previous one left.
// Reset: synchronous, active high; clears both valid flags and loads A = X = Y = 0,
//   SP = 0xFD and status = 0x24. No word is accepted during reset; a word held in either register is dropped.
module cpu_6502_execute_unit
   import c65eu_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_word
);

   // Input register: holds one accepted word until the execute stage takes it
   req_word_type   in_word_ff;
   logic           in_vld_ff;
   logic           in_vld_in;

   // Result register: holds the finished word until rsp accepts it
   rsp_word_type   rsp_word_ff;
   logic           rsp_vld_ff;
   logic           rsp_vld_in;

   // Architectural state
   arch_state_type state_ff;
   arch_state_type state_in;

   arch_state_type exec_state;
   rsp_word_type   exec_rsp;
   logic           advance;
   logic           req_take;

   c65eu_exec u_exec (
      .req_word  (in_word_ff),
      .cur_state (state_ff),
      .nxt_state (exec_state),
      .rsp_word  (exec_rsp)
   );

   // Advance the execute stage when the result register is free or being drained
   assign advance   = in_vld_ff && (!rsp_vld_ff || rsp_ready);
   // Hold off requests while reset is asserted
   assign req_ready = !reset && (!in_vld_ff || advance);
   assign req_take  = req_valid && req_ready;

   assign in_vld_in  = req_take || (in_vld_ff && !advance);
   assign rsp_vld_in = advance || (rsp_vld_ff && !rsp_ready);
   assign state_in   = advance ? exec_state : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff      <= 1'b0;
         rsp_vld_ff     <= 1'b0;
         state_ff.acc   <= 8'd0;
         state_ff.xreg  <= 8'd0;
         state_ff.yreg  <= 8'd0;
         state_ff.sp    <= RESET_SP;
         state_ff.flags <= RESET_FLAGS;
      end else begin
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         state_ff   <= state_in;
      end
   end

   // Payload registers: the input word loads on take, the result on advance; both hold otherwise
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_word_ff <= req_word;
      end
      if (advance) begin
         rsp_word_ff <= exec_rsp;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_word  = rsp_word_ff;

   // The state a waiting result reports is the live state
   a_rsp_matches_state: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> (rsp_word_ff.acc_out == state_ff.acc) &&
                     (rsp_word_ff.sp_out == state_ff.sp) &&
                     (rsp_word_ff.flags_out == state_ff.flags))
      else $error("result word disagrees with architectural state");

   // A stalled result freezes the state
   a_stall_holds_state: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && !rsp_ready |=> $stable(state_ff))
      else $error("state changed while result stalled");

   // A push drops SP by one
   a_push_dec_sp: assert property (@(posedge clock) disable iff (reset)
      advance && exec_rsp.stack_access |=> state_ff.sp == $past(state_ff.sp) - 8'd1)
      else $error("push did not decrement stack pointer");

   // Stack writes are always stores
   a_stack_is_store: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && rsp_word_ff.stack_access |-> rsp_word_ff.store_enable)
      else $error("stack access without store enable");

   // Unused status bit stays set
   a_unused_flag: assert property (@(posedge clock) disable iff (reset)
      state_ff.flags[FLAG_U])
      else $error("unused status bit cleared");

endmodule
